// ===== hdl/xrg_pkg.sv =====
// Package for the xorshift32 range generator: constants, configuration and
// mode codes, and the xorshift step and bit smear functions.
// No dependencies.
package xrg_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] DEFAULT_STATE = 32'h1234_5678;

    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 17;
    localparam int unsigned SHIFT_C = 5;

    // Configuration register indexes
    localparam logic CFG_SEED = 1'b0;
    localparam logic CFG_MODE = 1'b1;

    // Sampling modes
    localparam logic MODE_MODULO = 1'b0;
    localparam logic MODE_REJECT = 1'b1;

    typedef logic [DATA_W-1:0] word_t;

    function automatic word_t xs_advance(input word_t s);
        word_t u;
        u = s ^ (s << SHIFT_A);
        u = u ^ (u >> SHIFT_B);
        u = u ^ (u << SHIFT_C);
        return u;
    endfunction

    // Sets every bit below the highest set bit.
    function automatic word_t xs_smear(input word_t s);
        word_t u;
        u = s | (s >> 1);
        u = u | (u >> 2);
        u = u | (u >> 4);
        u = u | (u >> 8);
        u = u | (u >> 16);
        return u;
    endfunction

endpackage

// ===== hdl/xrg_rem_unit.sv =====
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// Depends on xrg_pkg.
module xrg_rem_unit
    import xrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  word_t       dividend,
    input  word_t       divisor,
    output logic        done,
    output word_t       remainder
);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    word_t            num_reg,   num_next;
    word_t            div_reg,   div_next;
    word_t            rem_reg,   rem_next;

    logic [DATA_W:0]   trial;
    logic [DATA_W+1:0] diff;

    // The partial remainder stays below the divisor, so the trial value
    // fits in 33 bits and a 34-bit difference shows the borrow cleanly.
    assign trial = {rem_reg, num_reg[DATA_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W - 1);
            num_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (diff[DATA_W+1])
            begin
                rem_next = trial[DATA_W-1:0];
            end
            else
            begin
                rem_next = diff[DATA_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/xorshift32_range_generator_top.sv =====
// Top level of the xorshift32 range generator: sequencer, generator state,
// configuration registers and output register.
// Depends on xrg_pkg and xrg_rem_unit.
//
//  channel  | direction | tdata (low bit up)             | tuser
//  ---------+-----------+--------------------------------+-------------
//  s_*      | in        | lower_bound[31:0], upper[31:0] | -
//  m_*      | out       | random_value[31:0]             | range_error
//  cfg_*    | in        | cfg_data: seed or mode bit     | -
//
// In modulo mode one item goes through accept, setup, one draw, 32 steps
// of the remainder unit, taking the remainder, and adding the lower bound.
// In rejection mode the sequencer draws again until the masked draw lies
// within the range. An empty range ends after the first draw with
// range_error set. s_tready is high only while the sequencer is idle.
// A finished item waits in the output register; if that is still full the
// sequencer holds its result. Reset loads the default generator state.
module xorshift32_range_generator_top
    import xrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // lower_bound[31:0], upper_bound[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // random_value[31:0]
    output logic        m_tuser    // range_error[0]
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DRAW = 3'd2;
    localparam logic [2:0] S_REM  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    word_t      gen_reg,   gen_next;
    logic       mode_reg,  mode_next;
    word_t      lo_reg,    lo_next;
    word_t      range_reg, range_next;
    word_t      maxv_reg,  maxv_next;
    word_t      mask_reg,  mask_next;
    word_t      offset_reg, offset_next;
    logic       err_reg,   err_next;
    logic       mvalid_reg, mvalid_next;
    word_t      mdata_reg, mdata_next;
    logic       muser_reg, muser_next;

    word_t      draw;
    word_t      masked;
    logic       rem_start;
    logic       rem_done;
    word_t      rem_value;
    logic       accept;

    assign accept = s_tvalid && (state_reg == S_IDLE);
    assign draw   = xs_advance(gen_reg);
    assign masked = draw & mask_reg;

    xrg_rem_unit u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (draw),
        .divisor   (range_reg),
        .done      (rem_done),
        .remainder (rem_value)
    );

    always_comb
    begin
        state_next  = state_reg;
        gen_next    = gen_reg;
        mode_next   = mode_reg;
        lo_next     = lo_reg;
        range_next  = range_reg;
        maxv_next   = maxv_reg;
        mask_next   = mask_reg;
        offset_next = offset_reg;
        err_next    = err_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        rem_start   = 1'b0;

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    lo_next    = s_tdata[31:0];
                    range_next = s_tdata[63:32] - s_tdata[31:0];
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                maxv_next  = range_reg - 1'b1;
                mask_next  = xs_smear(range_reg - 1'b1);
                state_next = S_DRAW;
            end
            S_DRAW:
            begin
                gen_next    = draw;
                offset_next = '0;
                err_next    = 1'b0;
                if (mode_reg == MODE_MODULO)
                begin
                    if (range_reg == '0)
                    begin
                        err_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rem_start  = 1'b1;
                        state_next = S_REM;
                    end
                end
                else if (maxv_reg[DATA_W-1])
                begin
                    err_next   = 1'b1;
                    state_next = S_OUT;
                end
                else if (masked <= maxv_reg)
                begin
                    offset_next = masked;
                    state_next  = S_OUT;
                end
            end
            S_REM:
            begin
                if (rem_done)
                begin
                    offset_next = rem_value;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = lo_reg + offset_reg;
                    muser_next  = err_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration is to be written only while idle; the block does not enforce it.
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEED:
                begin
                    if (cfg_data == '0)
                    begin
                        gen_next = DEFAULT_STATE;
                    end
                    else if (cfg_data[31])
                    begin
                        gen_next = '0 - cfg_data;
                    end
                    else
                    begin
                        gen_next = cfg_data;
                    end
                end
                CFG_MODE:
                begin
                    mode_next = cfg_data[0];
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            gen_reg    <= DEFAULT_STATE;
            mode_reg   <= MODE_MODULO;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            gen_reg    <= gen_next;
            mode_reg   <= mode_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        range_reg  <= range_next;
        maxv_reg   <= maxv_next;
        mask_reg   <= mask_next;
        offset_reg <= offset_next;
        err_reg    <= err_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

// ===== hdl/xrg_checker.sv =====
// Port-level checks for the xorshift32 range generator, bound to the top.
// Depends on xorshift32_range_generator_top.
module xrg_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser
);

    // Every item needs at least setup and one draw before ready returns.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
        else $error("ready returned too early after an accepted item");

    // No result can appear in the cycle after an accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared right after an item was accepted");

    // A new result is loaded at the same edge the sequencer goes idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while the sequencer is still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed or was dropped");

endmodule

bind xorshift32_range_generator_top xrg_checker u_xrg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
